@@ src/mwts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mwts_pkg;

  // field widths
  localparam int PRICE_W = 24;
  localparam int CHG_W   = PRICE_W + 1;
  localparam int SQ_W    = 2 * PRICE_W;
  localparam int WLEN_W  = 7;
  localparam int GAIN_W  = 12;
  localparam int THR_W   = 16;
  localparam int FRAC_W  = 8;
  localparam int SUM_W   = CHG_W + WLEN_W;
  localparam int QSUM_W  = SQ_W + WLEN_W;

  // divider and square root datapath
  localparam int WIDE_W     = 2 * SUM_W;
  localparam int ROOT_W     = WIDE_W / 2;
  localparam int DIV_DIGITS = 4;
  localparam int DIV_CYC    = WIDE_W / DIV_DIGITS;
  localparam int SQRT_STEPS = 2;
  localparam int SQRT_CYC   = ROOT_W / SQRT_STEPS;
  localparam int CYC_W      = $clog2(DIV_CYC);
  localparam int TM_W       = THR_W + WLEN_W + FRAC_W;
  localparam int GR_W       = GAIN_W + ROOT_W;
  localparam int CMP_W      = GR_W + 2;

  // job queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // register file
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_WLEN = 2'd0;
  localparam logic [1:0] REG_GAIN = 2'd1;
  localparam logic [1:0] REG_THR  = 2'd2;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd421;
  localparam logic [THR_W-1:0]  THR_RESET  = 16'd0;

  // signal codes
  localparam logic signed [1:0] SIG_HOLD = 2'sd0;
  localparam logic signed [1:0] SIG_BUY  = 2'sd1;
  localparam logic signed [1:0] SIG_SELL = -2'sd1;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               series_start;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0] signal;
    logic              window_ready;
  } out_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [QSUM_W-1:0]       qsum;
    logic [WLEN_W-1:0]       len;
    logic                    full;
    logic                    restart;
  } mwts_job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQD,
    F_SQO,
    F_UPD
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ,
    B_DIV,
    B_ABS,
    B_SQRT,
    B_MUL,
    B_DEC
  } back_state_t;

endpackage
`default_nettype wire

@@ src/moving_window_trend_signal.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   ports                              carries
// in        in_valid / in_ready / in_item      price, series_start
// out       out_valid / out_ready / out_item   signal, window_ready
// cfg       psel penable pwrite paddr pwdata   window_len, quantile_gain, trend_threshold
//
// an item with a full window goes through the back end in order: square of the sum,
// divide by the window length (4 quotient bits a cycle), difference, square root (2 root
// bits a cycle), gain multiply and decision; an item before the window fills only gets the
// decision. the front end uses the window memory and squarer, one item at a time.
// reset is synchronous and brings registers to 16 / 421 / 0; the window memory needs no
// clearing pass. a two entry job queue and the output register let either side stall.
module moving_window_trend_signal
  import mwts_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_item,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [WLEN_W-1:0] window_len_r;
  logic [GAIN_W-1:0] gain_r;
  logic [THR_W-1:0]  thr_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;
  logic              len_restart;

  logic      fq_valid;
  logic      fq_ready;
  mwts_job_t fq_job;
  logic      qb_valid;
  logic      qb_ready;
  mwts_job_t qb_job;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign cfg_idx     = paddr[ADDR_W-1:2];
  assign len_restart = cfg_wr && (cfg_idx == REG_WLEN);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WLEN_RESET;
      gain_r       <= GAIN_RESET;
      thr_r        <= THR_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WLEN: window_len_r <= pwdata[WLEN_W-1:0];
        REG_GAIN: gain_r       <= pwdata[GAIN_W-1:0];
        REG_THR:  thr_r        <= pwdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_WLEN: prdata = DATA_W'(window_len_r);
      REG_GAIN: prdata = DATA_W'(gain_r);
      REG_THR:  prdata = DATA_W'(thr_r);
      default:  prdata = '0;
    endcase
  end

  mwts_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (len_restart),
    .window_len (window_len_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .job_valid  (fq_valid),
    .job_ready  (fq_ready),
    .job        (fq_job)
  );

  mwts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  mwts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (len_restart),
    .gain      (gain_r),
    .threshold (thr_r),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // front end stays busy after taking an item
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("front end took items on consecutive cycles");

  // no trade decision before the window is full
  a_hold_until_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.window_ready |-> out_item.signal == SIG_HOLD)
    else $error("signal issued before window full");

  // signal code is buy, sell or hold
  a_signal_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.signal == SIG_HOLD || out_item.signal == SIG_BUY
                   || out_item.signal == SIG_SELL))
    else $error("bad signal code");

endmodule
`default_nettype wire

@@ src/mwts_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mwts_front
  import mwts_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              restart,
  input  wire logic [WLEN_W-1:0] window_len,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_item,
  output logic                   job_valid,
  input  wire logic              job_ready,
  output mwts_job_t              job
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int PW = AW + 1;

  front_state_t state_r, state_nxt;

  logic signed [CHG_W-1:0] mem [MAX_WINDOW];

  logic [PRICE_W-1:0]      prev_price_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [QSUM_W-1:0]       qsum_r;
  logic [WLEN_W-1:0]       fill_r;
  logic [AW-1:0]           wr_pos_r;
  logic signed [CHG_W-1:0] chg_r;
  logic signed [CHG_W-1:0] old_r;
  logic                    need_old_r;
  logic                    restart_r;
  logic [SQ_W-1:0]         dsq_r;
  logic [SQ_W-1:0]         osq_r;

  logic                    take;
  logic [WLEN_W-1:0]       len_eff;
  logic [WLEN_W-1:0]       fill_base;
  logic [AW-1:0]           pos_base;
  logic [PRICE_W-1:0]      prev_base;
  logic signed [CHG_W-1:0] chg;
  logic                    need_old;
  logic [PW-1:0]           pos_ext;
  logic [PW-1:0]           len_ext;
  logic [AW-1:0]           old_idx;
  logic [AW-1:0]           pos_inc;
  logic signed [CHG_W-1:0]   mul_in;
  logic signed [2*CHG_W-1:0] mul_p;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [QSUM_W-1:0]       qsum_nxt;

  // window length clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_len == '0) begin
      len_eff = WLEN_W'(1);
    end else if (32'(window_len) > MAX_WINDOW) begin
      len_eff = WLEN_W'(MAX_WINDOW);
    end else begin
      len_eff = window_len;
    end
  end

  // state sequence and handshake outputs
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    job_valid = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = F_SQD;
      end
      F_SQD: state_nxt = F_SQO;
      F_SQO: state_nxt = F_UPD;
      F_UPD: begin
        job_valid = 1'b1;
        if (job_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign take = in_valid && in_ready;

  // series restart folds into the bases of this item
  always_comb begin
    fill_base = in_item.series_start ? '0 : fill_r;
    pos_base  = in_item.series_start ? '0 : wr_pos_r;
    prev_base = in_item.series_start ? '0 : prev_price_r;
    if (fill_base == '0) begin
      chg = '0;
    end else begin
      chg = $signed({1'b0, in_item.price}) - $signed({1'b0, prev_base});
    end
    need_old = (fill_base >= len_eff);
    pos_ext  = PW'(pos_base);
    len_ext  = PW'(len_eff);
    if (pos_ext >= len_ext) begin
      old_idx = AW'(pos_ext - len_ext);
    end else begin
      old_idx = AW'(pos_ext + PW'(MAX_WINDOW) - len_ext);
    end
    pos_inc = (pos_base == AW'(MAX_WINDOW - 1)) ? '0 : pos_base + AW'(1);
  end

  // shared squarer for new and leaving change
  assign mul_in = (state_r == F_SQD) ? chg_r : old_r;
  assign mul_p  = mul_in * mul_in;

  // running sums after this item
  always_comb begin
    sum_nxt  = sum_r + SUM_W'(chg_r);
    qsum_nxt = qsum_r + QSUM_W'(dsq_r);
    if (need_old_r) begin
      sum_nxt  = sum_nxt - SUM_W'(old_r);
      qsum_nxt = qsum_nxt - QSUM_W'(osq_r);
    end
    job.sum     = sum_nxt;
    job.qsum    = qsum_nxt;
    job.len     = len_eff;
    job.full    = (fill_r >= len_eff);
    job.restart = restart_r;
  end

  // change window memory, read before write
  always_ff @(posedge clk) begin
    if (take) begin
      mem[pos_base] <= chg;
      old_r         <= mem[old_idx];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // series state
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      prev_price_r <= '0;
      sum_r        <= '0;
      qsum_r       <= '0;
      fill_r       <= '0;
      wr_pos_r     <= '0;
    end else if (take) begin
      prev_price_r <= in_item.price;
      wr_pos_r     <= pos_inc;
      fill_r       <= need_old ? fill_base : fill_base + WLEN_W'(1);
      if (in_item.series_start) begin
        sum_r  <= '0;
        qsum_r <= '0;
      end
    end else if (job_valid && job_ready) begin
      sum_r  <= sum_nxt;
      qsum_r <= qsum_nxt;
    end
  end

  // per item payload
  always_ff @(posedge clk) begin
    if (take) begin
      chg_r      <= chg;
      need_old_r <= need_old;
      restart_r  <= in_item.series_start;
    end
    if (state_r == F_SQD) dsq_r <= mul_p[SQ_W-1:0];
    if (state_r == F_SQO) osq_r <= mul_p[SQ_W-1:0];
  end

endmodule
`default_nettype wire

@@ src/mwts_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mwts_queue
  import mwts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire mwts_job_t push_job,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output mwts_job_t      pop_job
);

  localparam int QA_W = $clog2(QUEUE_DEPTH);

  mwts_job_t        slot_r [QUEUE_DEPTH];
  logic [QA_W-1:0]  wp_r;
  logic [QA_W-1:0]  rp_r;
  logic [QA_W:0]    cnt_r;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != (QA_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = slot_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + QA_W'(1);
      if (pop)  rp_r <= (rp_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + QA_W'(1);
      if (push && !pop) begin
        cnt_r <= cnt_r + (QA_W + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QA_W + 1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_job;
  end

endmodule
`default_nettype wire

@@ src/mwts_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mwts_back
  import mwts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              restart,
  input  wire logic [GAIN_W-1:0] gain,
  input  wire logic [THR_W-1:0]  threshold,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  wire mwts_job_t         job,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_item
);

  back_state_t state_r, state_nxt;

  mwts_job_t           job_r;
  logic [WIDE_W-1:0]   wide_r;
  logic [WLEN_W:0]     div_rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [ROOT_W+1:0]   srem_r;
  logic [CYC_W-1:0]    cnt_r;
  logic [GR_W-1:0]     gr_r;
  logic [TM_W-1:0]     tm_r;
  logic                holding_r;
  logic                out_valid_r;
  out_item_t           out_r;

  logic                    pop;
  logic                    load_out;
  logic [SUM_W-1:0]        sum_mag;
  logic [WLEN_W:0]         drem;
  logic [WIDE_W-1:0]       dquo;
  logic [WIDE_W-1:0]       qsum_ext;
  logic [ROOT_W-1:0]       sroot;
  logic [ROOT_W+1:0]       srem;
  logic [ROOT_W+1:0]       trial;
  logic [WIDE_W-1:0]       srad;
  logic [THR_W+WLEN_W-1:0] tprod;
  logic signed [CMP_W-1:0] s256;
  logic signed [CMP_W-1:0] gr_s;
  logic signed [CMP_W-1:0] tm_s;
  logic                    buy;
  logic                    sell;

  assign pop       = job_valid && job_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign load_out  = (state_r == B_DEC) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    job_ready = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) state_nxt = job.full ? B_SQ : B_DEC;
      end
      B_SQ:   state_nxt = B_DIV;
      B_DIV:  if (cnt_r == CYC_W'(DIV_CYC - 1)) state_nxt = B_ABS;
      B_ABS:  state_nxt = B_SQRT;
      B_SQRT: if (cnt_r == CYC_W'(SQRT_CYC - 1)) state_nxt = B_MUL;
      B_MUL:  state_nxt = B_DEC;
      B_DEC:  if (load_out) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // restoring divide by window length, DIV_DIGITS quotient bits a cycle
  always_comb begin
    drem = div_rem_r;
    dquo = wide_r;
    for (int i = 0; i < DIV_DIGITS; i++) begin
      drem = {drem[WLEN_W-1:0], dquo[WIDE_W-1]};
      dquo = {dquo[WIDE_W-2:0], 1'b0};
      if (drem >= {1'b0, job_r.len}) begin
        drem    = drem - {1'b0, job_r.len};
        dquo[0] = 1'b1;
      end
    end
  end

  // digit by digit square root, two root bits a cycle
  always_comb begin
    sroot = root_r;
    srem  = srem_r;
    srad  = wide_r;
    trial = '0;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      srem  = {srem[ROOT_W-1:0], srad[WIDE_W-1:WIDE_W-2]};
      srad  = {srad[WIDE_W-3:0], 2'b00};
      trial = {sroot, 2'b01};
      if (srem >= trial) begin
        srem  = srem - trial;
        sroot = {sroot[ROOT_W-2:0], 1'b1};
      end else begin
        sroot = {sroot[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // operands of the decision
  always_comb begin
    sum_mag  = job_r.sum[SUM_W-1] ? SUM_W'(-job_r.sum) : SUM_W'(job_r.sum);
    qsum_ext = WIDE_W'(job_r.qsum);
    tprod    = (THR_W + WLEN_W)'(threshold) * (THR_W + WLEN_W)'(job_r.len);
    s256     = CMP_W'(job_r.sum) <<< FRAC_W;
    gr_s     = $signed(CMP_W'(gr_r));
    tm_s     = $signed(CMP_W'(tm_r));
    buy      = job_r.full && !holding_r && ((s256 - gr_s) > tm_s);
    sell     = job_r.full && holding_r && ((s256 + gr_s) < -tm_s);
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // position and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (restart || (pop && job.restart)) begin
        holding_r <= 1'b0;
      end else if (load_out && (buy || sell)) begin
        holding_r <= buy;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) job_r <= job;
    if (load_out) begin
      if (buy) begin
        out_r.signal <= SIG_BUY;
      end else if (sell) begin
        out_r.signal <= SIG_SELL;
      end else begin
        out_r.signal <= SIG_HOLD;
      end
      out_r.window_ready <= job_r.full;
    end
    unique case (state_r)
      B_SQ: begin
        wide_r    <= WIDE_W'(sum_mag) * WIDE_W'(sum_mag);
        div_rem_r <= '0;
        cnt_r     <= '0;
      end
      B_DIV: begin
        wide_r    <= dquo;
        div_rem_r <= drem;
        cnt_r     <= cnt_r + CYC_W'(1);
      end
      B_ABS: begin
        wide_r <= (qsum_ext >= wide_r) ? qsum_ext - wide_r : wide_r - qsum_ext;
        tm_r   <= {tprod, {FRAC_W{1'b0}}};
        root_r <= '0;
        srem_r <= '0;
        cnt_r  <= '0;
      end
      B_SQRT: begin
        wide_r <= srad;
        root_r <= sroot;
        srem_r <= srem;
        cnt_r  <= cnt_r + CYC_W'(1);
      end
      B_MUL: begin
        gr_r <= GR_W'(gain) * GR_W'(root_r);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
